// File: rtl/ftbd_pkg.sv
// Shared types and constants for the FSK tape byte decoder.
package ftbd_pkg;

   localparam int unsigned DataBits      = 8;
   localparam int unsigned BitCountWidth = 4;
   localparam int unsigned AddrWidth     = 5;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [15:0] HighHalfPeriodReset = 16'd208;
   localparam logic [15:0] LowHalfPeriodReset  = 16'd417;
   localparam logic [14:0] ToleranceReset      = 15'd50;
   localparam logic [7:0]  LowNotesReset       = 8'd2;
   localparam logic [7:0]  HighNotesReset      = 8'd4;

   typedef enum logic [2:0] {
      CLASS_UNDER   = 3'd0,
      CLASS_HIGH    = 3'd1,
      CLASS_TRANS   = 3'd2,
      CLASS_LOW     = 3'd3,
      CLASS_OVER    = 3'd4,
      CLASS_UNKNOWN = 3'd5
   } interval_class_type;

   typedef enum logic [1:0] {
      NOTE_LOW     = 2'd0,
      NOTE_HIGH    = 2'd1,
      NOTE_TRANS   = 2'd2,
      NOTE_UNKNOWN = 2'd3
   } note_type;

   typedef enum logic [2:0] {
      REG_HIGH_HALF_PERIOD = 3'd0,
      REG_LOW_HALF_PERIOD  = 3'd1,
      REG_TOLERANCE        = 3'd2,
      REG_LOW_NOTES        = 3'd3,
      REG_HIGH_NOTES       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [15:0] high_half_period_us;
      logic [15:0] low_half_period_us;
      logic [14:0] tolerance_us;
      logic [7:0]  low_notes_per_bit;
      logic [7:0]  high_notes_per_bit;
   } cfg_type;

   typedef struct packed {
      logic               push;
      interval_class_type interval_class;
   } front_type;

   typedef struct packed {
      interval_class_type interval_class;
      logic               byte_ready;
      logic [7:0]         byte_value;
      logic               frame_error;
   } result_type;

endpackage

// File: rtl/ftbd_front.sv
// Front end: accepts edge intervals and classifies them against the tone windows.
module ftbd_front (
   input  ftbd_pkg::cfg_type   cfg,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [15:0]         req_edge_interval_us,
   output ftbd_pkg::front_type front
);
   import ftbd_pkg::*;

   logic signed [17:0] x_s;
   logic signed [17:0] h_s;
   logic signed [17:0] l_s;
   logic signed [17:0] w_s;
   logic signed [17:0] h_lo;
   logic signed [17:0] h_hi;
   logic signed [17:0] l_lo;
   logic signed [17:0] l_hi;

   assign x_s  = {2'b00, req_edge_interval_us};
   assign h_s  = {2'b00, cfg.high_half_period_us};
   assign l_s  = {2'b00, cfg.low_half_period_us};
   assign w_s  = {3'b000, cfg.tolerance_us};
   assign h_lo = h_s - w_s;
   assign h_hi = h_s + w_s;
   assign l_lo = l_s - w_s;
   assign l_hi = l_s + w_s;

   always_comb begin
      if (h_lo > x_s) begin
         front.interval_class = CLASS_UNDER;
      end else if (x_s < h_hi) begin
         front.interval_class = CLASS_HIGH;
      end else if (x_s < l_lo) begin
         front.interval_class = CLASS_TRANS;
      end else if ((l_lo <= x_s) && (x_s < l_hi)) begin
         front.interval_class = CLASS_LOW;
      end else if (l_hi < x_s) begin
         front.interval_class = CLASS_OVER;
      end else begin
         front.interval_class = CLASS_UNKNOWN;
      end
   end

   assign front.push = req_valid & ~req_stall;

endmodule

// File: rtl/ftbd_queue.sv
// Two-entry queue of classified intervals between front and back ends.
module ftbd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  ftbd_pkg::front_type          front,
   input  logic                         pop,
   output logic                         full,
   output logic                         not_empty,
   output ftbd_pkg::interval_class_type head
);
   import ftbd_pkg::*;

   interval_class_type entry_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = front.push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, front.push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (front.push) begin
         entry_ff[wr_ptr_ff] <= front.interval_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/ftbd_back.sv
// Back end: note runs, bit framing and the registered result stage.
module ftbd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ftbd_pkg::cfg_type            cfg,
   input  logic                         q_not_empty,
   input  ftbd_pkg::interval_class_type q_head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ftbd_pkg::result_type         result
);
   import ftbd_pkg::*;

   logic                           in_frame_ff;
   logic                           in_frame_in;
   note_type                       prev_note_ff;
   note_type                       prev_note_in;
   logic [7:0]                     run_length_ff;
   logic [7:0]                     run_length_in;
   logic [7:0]                     run_target_ff;
   logic [7:0]                     run_target_in;
   logic                           start_seen_ff;
   logic                           start_seen_in;
   logic [BitCountWidth-1:0]       bits_taken_ff;
   logic [BitCountWidth-1:0]       bits_taken_in;
   logic [DataBits-1:0]            shift_byte_ff;
   logic [DataBits-1:0]            shift_byte_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   result_type                     result_ff;
   result_type                     result_in;

   logic                           load;
   logic                           is_note;
   note_type                       note;
   logic [7:0]                     run_inc;
   logic                           bit_val;
   logic                           bit_fire;

   assign load      = ~rsp_valid_ff | ~rsp_stall;
   assign pop       = q_not_empty & load;
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;
   assign run_inc   = run_length_ff + 8'd1;

   always_comb begin
      is_note = 1'b0;
      note    = NOTE_UNKNOWN;
      case (q_head)
         CLASS_HIGH: begin
            is_note = 1'b1;
            note    = NOTE_HIGH;
         end
         CLASS_TRANS: begin
            is_note = 1'b1;
            note    = NOTE_TRANS;
         end
         CLASS_LOW: begin
            is_note = 1'b1;
            note    = NOTE_LOW;
         end
         default: begin
            is_note = 1'b0;
            note    = NOTE_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      prev_note_in  = prev_note_ff;
      run_length_in = run_length_ff;
      run_target_in = run_target_ff;
      start_seen_in = start_seen_ff;
      bits_taken_in = bits_taken_ff;
      shift_byte_in = shift_byte_ff;
      bit_fire      = 1'b0;
      bit_val       = (note == NOTE_HIGH);
      result_in.interval_class = q_head;
      result_in.byte_ready     = 1'b0;
      result_in.byte_value     = '0;
      result_in.frame_error    = 1'b0;

      if (pop && is_note && (in_frame_ff || (note == NOTE_LOW))) begin
         in_frame_in = 1'b1;
         if (note == prev_note_ff) begin
            run_length_in = run_inc;
            if (run_inc == run_target_ff) begin
               run_length_in = '0;
               bit_fire      = (note != NOTE_TRANS);
            end
         end else begin
            run_length_in = 8'd1;
            prev_note_in  = note;
            run_target_in = (note == NOTE_LOW) ? cfg.low_notes_per_bit
                                               : cfg.high_notes_per_bit;
         end
      end

      if (bit_fire) begin
         if (!start_seen_ff && !bit_val) begin
            start_seen_in = 1'b1;
         end else if (start_seen_ff && (bits_taken_ff < BitCountWidth'(DataBits))) begin
            shift_byte_in = shift_byte_ff
                          | (DataBits'(bit_val) << bits_taken_ff[$clog2(DataBits)-1:0]);
            bits_taken_in = bits_taken_ff + 1'b1;
         end else if ((bits_taken_ff == BitCountWidth'(DataBits)) && bit_val) begin
            result_in.byte_ready = 1'b1;
            result_in.byte_value = shift_byte_ff;
            start_seen_in        = 1'b0;
            bits_taken_in        = '0;
            shift_byte_in        = '0;
            in_frame_in          = 1'b0;
         end else begin
            result_in.frame_error = 1'b1;
         end
      end

      rsp_valid_in = load ? q_not_empty : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         prev_note_ff  <= NOTE_UNKNOWN;
         run_length_ff <= '0;
         run_target_ff <= '0;
         start_seen_ff <= 1'b0;
         bits_taken_ff <= '0;
         shift_byte_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         prev_note_ff  <= prev_note_in;
         run_length_ff <= run_length_in;
         run_target_ff <= run_target_in;
         start_seen_ff <= start_seen_in;
         bits_taken_ff <= bits_taken_in;
         shift_byte_ff <= shift_byte_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/fsk_tape_byte_decoder.sv
// Top level of the FSK tape byte decoder: register port, front end, queue, back end.
// An accepted item is written into the queue, then popped into the registered result
// stage once the queue holds nothing older and the result stage is free to load.
// Throughput: one item per cycle while req_stall is low; the two-entry queue and the
// result register decouple the input side from a stalled output side.
// Reset (synchronous, active high): empties queue and result stage, clears the framing
// state and loads the register defaults 208, 417, 50, 2 and 4.
module fsk_tape_byte_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [15:0]                        req_edge_interval_us,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_interval_class,
   output logic                               rsp_byte_ready,
   output logic [7:0]                         rsp_byte_value,
   output logic                               rsp_frame_error,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ftbd_pkg::AddrWidth-1:0]     paddr,
   input  logic [ftbd_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [ftbd_pkg::CsrDataWidth-1:0]  prdata,
   output logic                               pready
);
   import ftbd_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   reg_index_type      reg_index;
   logic               wr_en;
   front_type          front;
   logic               q_full;
   logic               q_not_empty;
   interval_class_type q_head;
   logic               pop;
   result_type         result;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = reg_index_type'(paddr[AddrWidth-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_index)
         REG_HIGH_HALF_PERIOD: begin
            prdata = CsrDataWidth'(cfg_ff.high_half_period_us);
            if (wr_en) cfg_in.high_half_period_us = pwdata[15:0];
         end
         REG_LOW_HALF_PERIOD: begin
            prdata = CsrDataWidth'(cfg_ff.low_half_period_us);
            if (wr_en) cfg_in.low_half_period_us = pwdata[15:0];
         end
         REG_TOLERANCE: begin
            prdata = CsrDataWidth'(cfg_ff.tolerance_us);
            if (wr_en) cfg_in.tolerance_us = pwdata[14:0];
         end
         REG_LOW_NOTES: begin
            prdata = CsrDataWidth'(cfg_ff.low_notes_per_bit);
            if (wr_en) cfg_in.low_notes_per_bit = pwdata[7:0];
         end
         REG_HIGH_NOTES: begin
            prdata = CsrDataWidth'(cfg_ff.high_notes_per_bit);
            if (wr_en) cfg_in.high_notes_per_bit = pwdata[7:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_half_period_us <= HighHalfPeriodReset;
         cfg_ff.low_half_period_us  <= LowHalfPeriodReset;
         cfg_ff.tolerance_us        <= ToleranceReset;
         cfg_ff.low_notes_per_bit   <= LowNotesReset;
         cfg_ff.high_notes_per_bit  <= HighNotesReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   ftbd_front u_front (
      .cfg                  (cfg_ff),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_edge_interval_us (req_edge_interval_us),
      .front                (front)
   );

   ftbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .front     (front),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   ftbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .result      (result)
   );

   assign rsp_interval_class = result.interval_class;
   assign rsp_byte_ready     = result.byte_ready;
   assign rsp_byte_value     = result.byte_value;
   assign rsp_frame_error    = result.frame_error;

endmodule

// File: rtl/ftbd_checker.sv
// Port-level checks for the FSK tape byte decoder, bound to the top level.
module ftbd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [2:0]                        rsp_interval_class,
   input logic                              rsp_byte_ready,
   input logic [7:0]                        rsp_byte_value,
   input logic                              rsp_frame_error
);
   import ftbd_pkg::*;

   a_byte_or_error : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_byte_ready && rsp_frame_error))
      else $error("byte and frame error in one result");

   a_value_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_ready) |-> (rsp_byte_value == 8'd0))
      else $error("byte value not zero without a byte");

   a_bit_from_tone : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_byte_ready || rsp_frame_error)) |->
      ((rsp_interval_class == CLASS_HIGH) || (rsp_interval_class == CLASS_LOW)))
      else $error("bit event on a non-tone interval");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_interval_class) && $stable(rsp_byte_ready)
       && $stable(rsp_byte_value) && $stable(rsp_frame_error)))
      else $error("stalled result changed");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result or stall present after reset");

endmodule

bind fsk_tape_byte_decoder ftbd_checker u_ftbd_checker (.*);
